FILE: rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared constants and types for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int CAP_RST = (ENTRIES < 16) ? ENTRIES : 16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic                    valid;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic cmp;
    logic load;
  } cell_ctrl_t;

endpackage

FILE: rtl/lkv_req_if.sv
// ----------------------------------------------------------------------------
// lkv_req_if
// Request channel: get or put with key and value.
// ----------------------------------------------------------------------------
interface lkv_req_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     operation;
  logic [lkv_pkg::KEY_W-1:0]                key;
  logic signed [lkv_pkg::VAL_W-1:0]         value;

  modport source (output valid, output operation, output key, output value, input ready);
  modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

FILE: rtl/lkv_rsp_if.sv
// ----------------------------------------------------------------------------
// lkv_rsp_if
// Response channel: found flag and read value.
// ----------------------------------------------------------------------------
interface lkv_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             found;
  logic signed [lkv_pkg::VAL_W-1:0] read_value;

  modport source (output valid, output found, output read_value, input ready);
  modport sink   (input valid, input found, input read_value, output ready);
endinterface

FILE: rtl/lkv_cell.sv
// ----------------------------------------------------------------------------
// lkv_cell
// One position of the recency-ordered entry chain with its key comparator.
// ----------------------------------------------------------------------------
module lkv_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lkv_pkg::cell_ctrl_t          ctrl_i,
  input  logic [lkv_pkg::KEY_W-1:0]    key_i,
  input  lkv_pkg::entry_t              entry_i,
  output lkv_pkg::entry_t              entry_o,
  output logic                         hit_o
);
  import lkv_pkg::*;

  logic             valid_q;
  logic [KEY_W-1:0] key_q;
  logic signed [VAL_W-1:0] value_q;
  logic             hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      if (ctrl_i.clear) begin
        valid_q <= 1'b0;
      end else if (ctrl_i.load) begin
        valid_q <= entry_i.valid;
      end
      if (ctrl_i.cmp) begin
        hit_q <= valid_q && (key_q == key_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      key_q   <= entry_i.key;
      value_q <= entry_i.value;
    end
  end

  assign entry_o = '{valid: valid_q, key: key_q, value: value_q};
  assign hit_o   = hit_q;

endmodule

FILE: rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Entries sit in a chain of cells ordered by recency, cell 0 most recent.
// A request is compared against every cell at the edge it is accepted; in the
// update state that follows, a hit or a put shifts the chain one place up to
// the hit, eviction or free position and the request's entry lands in cell 0,
// and the response is registered. A new request is not accepted until the
// update of the last one is done; a stalled response register holds the
// update until it is free. A capacity write empties the store.
module lru_key_value_cache (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lkv_pkg::CAP_W-1:0]   cfg_wdata_i,
  lkv_req_if.sink                     req_i,
  lkv_rsp_if.source                   rsp_o
);
  import lkv_pkg::*;

  state_e state_q, state_d;
  logic [CNT_W-1:0] occ_q, occ_d;
  logic [CNT_W-1:0] cap_q;
  logic             op_q;
  logic [KEY_W-1:0] key_q;
  logic signed [VAL_W-1:0] value_q;
  logic             rsp_valid_q, rsp_valid_d;
  logic             found_q;
  logic signed [VAL_W-1:0] read_value_q;

  cell_ctrl_t ctrl [ENTRIES];
  entry_t     cell_out [ENTRIES];
  entry_t     cell_in [ENTRIES];
  logic [ENTRIES-1:0] hit;

  logic             accept, do_upd, hit_any, full, change;
  logic [IDX_W-1:0] hit_pos, top_pos;
  logic [CNT_W-1:0] occ_m1;
  logic signed [VAL_W-1:0] hit_val;
  entry_t           head;

  function automatic logic [CNT_W-1:0] clamp_cap(logic [CAP_W-1:0] v);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    if (w == '0) begin
      return CNT_W'(1);
    end else if (w > CMP_W'(ENTRIES)) begin
      return CNT_W'(ENTRIES);
    end
    return CNT_W'(w);
  endfunction

  assign accept = req_i.valid && req_i.ready;

  always_comb begin
    hit_pos = '0;
    hit_val = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit[i]) begin
        hit_pos = hit_pos | IDX_W'(i);
        hit_val = hit_val | cell_out[i].value;
      end
    end
  end

  assign hit_any = |hit;
  assign full    = occ_q >= cap_q;
  assign occ_m1  = occ_q - CNT_W'(1);
  assign top_pos = hit_any ? hit_pos : (full ? occ_m1[IDX_W-1:0] : occ_q[IDX_W-1:0]);
  assign change  = hit_any || (op_q == OP_PUT);
  assign head    = '{valid: 1'b1, key: key_q,
                     value: (op_q == OP_PUT) ? value_q : hit_val};

  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    do_upd      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          do_upd  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    occ_d = occ_q;
    if (cfg_we_i) begin
      occ_d = '0;
    end else if (do_upd && (op_q == OP_PUT) && !hit_any && !full) begin
      occ_d = occ_q + CNT_W'(1);
    end
    rsp_valid_d = rsp_valid_q;
    if (do_upd) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_in[i] = head;
    end else begin : g_body
      assign cell_in[i] = cell_out[i-1];
    end
    assign ctrl[i] = '{clear: cfg_we_i, cmp: accept,
                       load: do_upd && change && (IDX_W'(i) <= top_pos)};

    lkv_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl[i]),
      .key_i   (req_i.key),
      .entry_i (cell_in[i]),
      .entry_o (cell_out[i]),
      .hit_o   (hit[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      cap_q       <= CNT_W'(CAP_RST);
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        cap_q <= clamp_cap(cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= req_i.operation;
      key_q   <= req_i.key;
      value_q <= req_i.value;
    end
    if (do_upd) begin
      found_q      <= hit_any;
      read_value_q <= (hit_any && (op_q == OP_GET)) ? hit_val : '0;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.found      = found_q;
  assign rsp_o.read_value = read_value_q;

endmodule

FILE: rtl/lkv_checker.sv
// ----------------------------------------------------------------------------
// lkv_checker
// Port-level checks for the LRU key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic        rsp_found_i,
  input logic [31:0] rsp_read_value_i
);

  logic [1:0] pend_q;
  logic       req_xfer, rsp_xfer;

  assign req_xfer = req_valid_i && req_ready_i;
  assign rsp_xfer = rsp_valid_i && rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (req_xfer && !rsp_xfer) begin
      pend_q <= pend_q + 2'd1;
    end else if (!req_xfer && rsp_xfer) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped before transfer");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer |=> !req_ready_i)
    else $error("request taken while previous one in work");

  a_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many requests without response");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_found_i |-> rsp_read_value_i == 32'd0)
    else $error("miss response carries nonzero value");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_found_i      (rsp_o.found),
  .rsp_read_value_i (rsp_o.read_value)
);
